// ===== hdl/rbd_pkg.sv =====
// Shared types and constants of the bus decoder and keyboard/display PIA.
`default_nettype none
package rbd_pkg;

  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_PEEK    = 3'd2;
  localparam logic [2:0] OP_KEY     = 3'd3;
  localparam logic [2:0] OP_PRELOAD = 3'd4;

  localparam logic [2:0] CFG_RAM_SIZE  = 3'd0;
  localparam logic [2:0] CFG_IO_CARD   = 3'd1;
  localparam logic [2:0] CFG_BASIC     = 3'd2;
  localparam logic [2:0] CFG_ACI       = 3'd3;
  localparam logic [2:0] CFG_DISK_ROM  = 3'd4;

  localparam logic [1:0] CARD_CASSETTE = 2'd1;
  localparam logic [1:0] CARD_DISK     = 2'd2;

  localparam logic [1:0] PIA_KBD       = 2'd0;
  localparam logic [1:0] PIA_KBDCR     = 2'd1;
  localparam logic [1:0] PIA_DSP       = 2'd2;
  localparam logic [1:0] PIA_DSPCR     = 2'd3;

  localparam logic [1:0] SRC_CONST     = 2'd0;
  localparam logic [1:0] SRC_STORE     = 2'd1;
  localparam logic [1:0] SRC_LATCH     = 2'd2;

  localparam logic [7:0] KEY_STROBE    = 8'h80;
  localparam logic [7:0] CHAR_MASK     = 8'h7F;

  localparam int CARD_RAM_DEPTH  = 4096;
  localparam int BASIC_DEPTH     = 4096;
  localparam int CASSETTE_DEPTH  = 256;
  localparam int DISK_ROM_DEPTH  = 512;
  localparam int MONITOR_DEPTH   = 256;
  localparam int STORE_EXTRA     = CARD_RAM_DEPTH + BASIC_DEPTH + CASSETTE_DEPTH
                                   + DISK_ROM_DEPTH + MONITOR_DEPTH;

  localparam logic [15:0] CARD_RAM_LO = 16'h2000;
  localparam logic [15:0] WINDOW_LO   = 16'hC100;
  localparam logic [15:0] WINDOW_HI   = 16'hC2FF;
  localparam logic [3:0]  CARD_RAM_HI_NIB = 4'h2;
  localparam logic [3:0]  BASIC_NIB   = 4'hE;
  localparam logic [7:0]  SWITCH_PAGE = 8'hC0;
  localparam logic [7:0]  PIA_PAGE    = 8'hD0;
  localparam logic [7:0]  MONITOR_PAGE = 8'hFF;

  typedef struct packed {
    logic [1:0] ram_size_select;
    logic [1:0] io_card;
    logic       basic_present;
    logic       aci_present;
    logic       disk_rom_present;
  } cfg_t;

  typedef struct packed {
    logic rd0;
    logic rd1;
    logic disp_wr;
    logic disp_en;
    logic key_push;
  } pia_ctl_t;

  typedef struct packed {
    logic [7:0] rd1_byte;
    logic       disp_on;
    logic       dropped;
  } pia_stat_t;

  typedef struct packed {
    logic        st_re;
    logic        st_we;
    logic [15:0] st_addr;
    logic [1:0]  src;
    logic        cardio;
    pia_ctl_t    pia;
  } dec_t;

endpackage
`default_nettype wire

// ===== hdl/rbd_ram.sv =====
// Generic synchronous RAM with one write port and one registered read port.
`default_nettype none
module rbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/rbd_decode.sv =====
// Address decoder: turns one bus word into store accesses, PIA actions and a card I/O flag.
`default_nettype none
module rbd_decode
  import rbd_pkg::*;
#(
  parameter int MAIN_RAM_DEPTH = 32768
) (
  input  wire logic [2:0]  opcode,
  input  wire logic [15:0] address,
  input  wire cfg_t        cfg,
  output dec_t             dec
);

  localparam logic [16:0] MAIN_LIM  = 17'(MAIN_RAM_DEPTH);
  localparam logic [15:0] CARD_BASE = 16'(MAIN_RAM_DEPTH);
  localparam logic [15:0] BASIC_BASE = 16'(MAIN_RAM_DEPTH + CARD_RAM_DEPTH);
  localparam logic [15:0] CAS_BASE  = 16'(MAIN_RAM_DEPTH + CARD_RAM_DEPTH + BASIC_DEPTH);
  localparam logic [15:0] DISK_BASE = 16'(MAIN_RAM_DEPTH + CARD_RAM_DEPTH + BASIC_DEPTH
                                          + CASSETTE_DEPTH);
  localparam logic [15:0] MON_BASE  = 16'(MAIN_RAM_DEPTH + CARD_RAM_DEPTH + BASIC_DEPTH
                                          + CASSETTE_DEPTH + DISK_ROM_DEPTH);

  logic [16:0] ext_raw;
  logic [16:0] extent;
  logic [15:0] win_off;
  logic        in_card;
  logic        in_main;
  logic        in_basic;
  logic        in_win;
  logic        in_sw;
  logic        in_pia;
  logic        in_mon;
  logic        is_cas;
  logic        is_disk;
  logic        sw_flag;
  logic [15:0] a_card;
  logic [15:0] a_basic;
  logic [15:0] a_cas;
  logic [15:0] a_disk;
  logic [15:0] a_mon;
  logic        reading;

  always_comb begin
    ext_raw  = {({1'b0, cfg.ram_size_select} + 3'd1), 14'b0} >> 1;
    extent   = (ext_raw > MAIN_LIM) ? MAIN_LIM : ext_raw;
    win_off  = address - WINDOW_LO;
    in_card  = (cfg.io_card == CARD_DISK) && (address[15:12] == CARD_RAM_HI_NIB);
    in_main  = {1'b0, address} < extent;
    in_basic = address[15:12] == BASIC_NIB;
    in_win   = address inside {[WINDOW_LO:WINDOW_HI]};
    in_sw    = address[15:8] == SWITCH_PAGE;
    in_pia   = address[15:8] == PIA_PAGE;
    in_mon   = address[15:8] == MONITOR_PAGE;
    is_cas   = (cfg.io_card == CARD_CASSETTE) && !win_off[8];
    is_disk  = cfg.io_card == CARD_DISK;
    sw_flag  = (cfg.io_card == CARD_CASSETTE)
               || (is_disk && (address[7:4] == 4'h0));
    a_card   = CARD_BASE + {4'b0, address[11:0] - CARD_RAM_LO[11:0]};
    a_basic  = BASIC_BASE + {4'b0, address[11:0]};
    a_cas    = CAS_BASE + {8'b0, win_off[7:0]};
    a_disk   = DISK_BASE + {7'b0, win_off[8:0]};
    a_mon    = MON_BASE + {8'b0, address[7:0]};
    reading  = (opcode == OP_READ) || (opcode == OP_PEEK);

    dec = '0;
    dec.src = SRC_CONST;

    if (in_card) begin
      dec.st_addr = a_card;
    end else if (in_main) begin
      dec.st_addr = address;
    end else if (in_basic) begin
      dec.st_addr = a_basic;
    end else if (in_win) begin
      dec.st_addr = is_disk ? a_disk : a_cas;
    end else begin
      dec.st_addr = a_mon;
    end

    case (opcode)
      OP_READ, OP_PEEK: begin
        if (in_card || in_main) begin
          dec.st_re = 1'b1;
        end else if (in_basic) begin
          dec.st_re = cfg.basic_present;
        end else if (in_win) begin
          dec.st_re = (is_cas && cfg.aci_present) || (is_disk && cfg.disk_rom_present);
        end else if (in_sw) begin
          dec.cardio = (opcode == OP_READ) && sw_flag;
        end else if (in_pia) begin
          if (opcode == OP_READ) begin
            dec.pia.rd0 = address[1:0] == PIA_KBD;
            dec.pia.rd1 = address[1:0] == PIA_KBDCR;
            if (address[1:0] == PIA_KBD) begin
              dec.src = SRC_LATCH;
            end
          end
        end else if (in_mon) begin
          dec.st_re = 1'b1;
        end
        if (dec.st_re) begin
          dec.src = SRC_STORE;
        end
      end
      OP_WRITE: begin
        if (in_card || in_main) begin
          dec.st_we = 1'b1;
        end else if (in_basic) begin
          dec.st_we = cfg.basic_present;
        end else if (in_pia) begin
          dec.pia.disp_wr = address[1:0] == PIA_DSP;
          dec.pia.disp_en = address[1:0] == PIA_DSPCR;
        end else if (in_sw) begin
          dec.cardio = is_disk && (address[7:4] == 4'h0);
        end
      end
      OP_KEY: begin
        dec.pia.key_push = 1'b1;
      end
      OP_PRELOAD: begin
        if (in_card || in_main || in_basic) begin
          dec.st_we = 1'b1;
        end else if (in_win) begin
          dec.st_we = is_cas || is_disk;
        end else if (in_mon) begin
          dec.st_we = 1'b1;
        end
      end
      default: begin
        dec = '0;
      end
    endcase

    if (!reading) begin
      dec.st_re = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rbd_pia.sv =====
// Keyboard/display PIA: key FIFO in RAM, key latch, ready flag and display enable.
`default_nettype none
module rbd_pia
  import rbd_pkg::*;
#(
  parameter int KEY_FIFO_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire pia_ctl_t   ctl,
  input  wire logic [7:0] key_in,
  input  wire logic       advance,
  output pia_stat_t       stat,
  output logic [7:0]      key_latch
);

  localparam int KAW = (KEY_FIFO_DEPTH > 1) ? $clog2(KEY_FIFO_DEPTH) : 1;
  localparam int CW  = $clog2(KEY_FIFO_DEPTH + 1);
  localparam logic [KAW-1:0] LAST = KAW'(KEY_FIFO_DEPTH - 1);
  localparam logic [CW-1:0]  FULL = CW'(KEY_FIFO_DEPTH);

  logic [KAW-1:0] head_r, head_nxt;
  logic [KAW-1:0] tail_r, tail_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           key_ready_r, key_ready_nxt;
  logic           disp_en_r, disp_en_nxt;
  logic           pend_r, pend_nxt;
  logic [7:0]     latch_r, latch_nxt;
  logic           full;
  logic           empty;
  logic           pop;
  logic           push_ok;
  logic [7:0]     fifo_rdata;

  always_comb begin
    full    = cnt_r == FULL;
    empty   = cnt_r == '0;
    pop     = accept && ctl.rd1 && !key_ready_r && !empty;
    push_ok = accept && ctl.key_push && !full;

    stat.rd1_byte = (key_ready_r || !empty) ? KEY_STROBE : 8'h00;
    stat.disp_on  = disp_en_r;
    stat.dropped  = ctl.key_push && full;

    head_nxt = pop ? ((head_r == LAST) ? '0 : head_r + 1'b1) : head_r;
    tail_nxt = push_ok ? ((tail_r == LAST) ? '0 : tail_r + 1'b1) : tail_r;
    cnt_nxt  = cnt_r + CW'(push_ok) - CW'(pop);

    key_ready_nxt = key_ready_r;
    if (pop) begin
      key_ready_nxt = 1'b1;
    end else if (accept && ctl.rd0) begin
      key_ready_nxt = 1'b0;
    end

    disp_en_nxt = disp_en_r || (accept && ctl.disp_en);

    latch_nxt = (pend_r && advance) ? (fifo_rdata | KEY_STROBE) : latch_r;
    pend_nxt  = pop ? 1'b1 : (advance ? 1'b0 : pend_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      key_ready_r <= 1'b0;
      disp_en_r   <= 1'b0;
      pend_r      <= 1'b0;
      latch_r     <= 8'h00;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      key_ready_r <= key_ready_nxt;
      disp_en_r   <= disp_en_nxt;
      pend_r      <= pend_nxt;
      latch_r     <= latch_nxt;
    end
  end

  rbd_ram #(
    .WIDTH (8),
    .DEPTH (KEY_FIFO_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (tail_r),
    .wdata (key_in),
    .re    (pop),
    .raddr (head_r),
    .rdata (fifo_rdata)
  );

  assign key_latch = latch_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL)
    else $error("key FIFO count above its depth");

  a_pop_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> key_ready_r && pend_r)
    else $error("key pop did not raise ready");

endmodule
`default_nettype wire

// ===== hdl/retro_bus_decode_and_pia_core.sv =====
// Top level: bus decoder, shared store RAM, PIA and the result pipeline.
`default_nettype none
// One bus word is taken per clock cycle while in_stall is low; its result word passes through
// the second stage and the output register before it is presented.
// The decode and the flag and FIFO updates of the PIA happen at acceptance; a popped key
// reaches the key latch as its word leaves the second stage. The single
// store RAM (main RAM, card RAM, BASIC RAM and the three ROMs) has a registered
// read, so a second stage collects the byte and an output register
// holds the result, letting a new word in while a finished one waits. Each
// store is read or written once per word, so one port pair sustains that rate.
// The stores are not cleared by reset; the user must write configuration only when idle, unenforced.
module retro_bus_decode_and_pia_core
  import rbd_pkg::*;
#(
  parameter int MAIN_RAM_DEPTH = 32768,
  parameter int KEY_FIFO_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_data_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_read_data,
  output logic             out_display_valid,
  output logic [6:0]       out_display_char,
  output logic             out_card_io_access,
  output logic             out_key_dropped
);

  localparam int STORE_DEPTH = MAIN_RAM_DEPTH + STORE_EXTRA;
  localparam int SAW = $clog2(STORE_DEPTH);

  cfg_t       cfg_r, cfg_nxt;
  dec_t       dec;
  pia_stat_t  pia_stat;
  logic [7:0] key_latch;
  logic [7:0] st_rdata;
  logic       accept;
  logic       out_load;

  logic       s1_v_r, s1_v_nxt;
  logic [1:0] s1_src_r;
  logic [7:0] s1_cdata_r;
  logic       s1_dvalid_r;
  logic [6:0] s1_dchar_r;
  logic       s1_cardio_r;
  logic       s1_dropped_r;

  logic       out_v_r, out_v_nxt;
  logic [7:0] out_data_r;
  logic       out_dvalid_r;
  logic [6:0] out_dchar_r;
  logic       out_cardio_r;
  logic       out_dropped_r;
  logic [7:0] sel_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_RAM_SIZE: cfg_nxt.ram_size_select  = cfg_data;
        CFG_IO_CARD:  cfg_nxt.io_card          = cfg_data;
        CFG_BASIC:    cfg_nxt.basic_present    = cfg_data[0];
        CFG_ACI:      cfg_nxt.aci_present      = cfg_data[0];
        CFG_DISK_ROM: cfg_nxt.disk_rom_present = cfg_data[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  rbd_decode #(
    .MAIN_RAM_DEPTH (MAIN_RAM_DEPTH)
  ) u_decode (
    .opcode  (in_opcode),
    .address (in_address),
    .cfg     (cfg_r),
    .dec     (dec)
  );

  always_comb begin
    out_load  = s1_v_r && (!out_v_r || !out_stall);
    in_stall  = s1_v_r && !out_load;
    accept    = in_valid && !in_stall;
    s1_v_nxt  = accept ? 1'b1 : (out_load ? 1'b0 : s1_v_r);
    out_v_nxt = out_load ? 1'b1 : (out_stall ? out_v_r : 1'b0);
    case (s1_src_r)
      SRC_STORE: sel_data = st_rdata;
      SRC_LATCH: sel_data = key_latch;
      default:   sel_data = s1_cdata_r;
    endcase
  end

  rbd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && dec.st_we),
    .waddr (dec.st_addr[SAW-1:0]),
    .wdata (in_data_in),
    .re    (accept && dec.st_re),
    .raddr (dec.st_addr[SAW-1:0]),
    .rdata (st_rdata)
  );

  rbd_pia #(
    .KEY_FIFO_DEPTH (KEY_FIFO_DEPTH)
  ) u_pia (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .ctl       (dec.pia),
    .key_in    (in_data_in),
    .advance   (out_load),
    .stat      (pia_stat),
    .key_latch (key_latch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src_r     <= dec.src;
      s1_cdata_r   <= dec.pia.rd1 ? pia_stat.rd1_byte : 8'h00;
      s1_dvalid_r  <= dec.pia.disp_wr && pia_stat.disp_on;
      s1_dchar_r   <= (dec.pia.disp_wr && pia_stat.disp_on)
                      ? in_data_in[6:0] & CHAR_MASK[6:0] : 7'h00;
      s1_cardio_r  <= dec.cardio;
      s1_dropped_r <= pia_stat.dropped;
    end
    if (out_load) begin
      out_data_r    <= sel_data;
      out_dvalid_r  <= s1_dvalid_r;
      out_dchar_r   <= s1_dchar_r;
      out_cardio_r  <= s1_cardio_r;
      out_dropped_r <= s1_dropped_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_read_data      = out_data_r;
  assign out_display_valid  = out_dvalid_r;
  assign out_display_char   = out_dchar_r;
  assign out_card_io_access = out_cardio_r;
  assign out_key_dropped    = out_dropped_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted word did not enter the second stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_load |=> s1_v_r && $stable(s1_src_r))
    else $error("second stage lost a word while the output was stalled");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_dvalid_r |-> out_dchar_r == 7'h00)
    else $error("display character set without a display word");

endmodule
`default_nettype wire
